[rtl/assert_macros.svh]
// Assertion macros used by the top RTL file of the motion profile block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tmp_pkg.sv]
// Package with the payload types and codes of the trapezoidal motion profile block.
`default_nettype none

package tmp_pkg;

    localparam int W = 32;

    typedef enum logic [1:0] {
        PH_ACCEL   = 2'd0,
        PH_CRUISE  = 2'd1,
        PH_DECEL   = 2'd2,
        PH_ARRIVED = 2'd3
    } t_phase;

    typedef enum logic [0:0] {
        REG_MAX_SPEED  = 1'b0,
        REG_ACCEL_RATE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [W-1:0] start_position;
        logic signed [W-1:0] goal_position;
        logic [W-1:0]        elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic signed [W-1:0] planned_position;
        t_phase              move_phase;
        logic                triangular;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/trapezoid_motion_profile.sv]
// The depth from an input transfer to its result does not depend on FRAC_BITS.
// Throughput: one item per cycle when the output is not stalled; a 64-cell
// divider row and a 63-cell row of three parallel dividers (one quotient bit
// per cell) set the depth. The whole pipeline holds while a result waits on
// a stalled output. Reset (synchronous, active low) empties the pipeline and
// sets both speed and acceleration registers to 1.0.
`default_nettype none

module trapezoid_motion_profile
    import tmp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_we,
    input  wire t_reg_idx  i_cfg_idx,
    input  wire logic [W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    // Pipeline geometry. The first row divides v*v by a and, alongside, takes
    // the square root of d*a in its first NS cells. The second row computes the
    // ramp time, the cruise time and the ramp distance.
    localparam int NA     = 2 * W;
    localparam int NS     = W;
    localparam int NB     = 2 * W - 1;
    localparam int TW     = W + FRAC_BITS;
    localparam int EW     = TW + 2;
    localparam int PW     = 3 * W;
    localparam int P1_IDX = 3 + NA;
    localparam int LAT    = 5 + NA + NB + 9;

    // Item data that travels beside the arithmetic; later fields fill in as
    // the item moves down the pipeline.
    typedef struct packed {
        logic signed [W-1:0] start;
        logic signed [W-1:0] goal;
        logic [W-1:0]        t;
        logic [W-1:0]        d;
        logic                up;
        logic [2*W-1:0]      tt;
        logic [W-1:0]        root;
        logic                trap;
        logic [W-1:0]        vp;
        logic [W-1:0]        dq;
    } t_sb;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // Configuration. A zero acts as the smallest step, so it is stored as one.
    logic [W-1:0] r_max_speed;
    logic [W-1:0] r_accel_rate;
    logic [W-1:0] w_cfg_val;

    assign w_cfg_val = (i_cfg_data == '0) ? W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= W'(1) << FRAC_BITS;
            r_accel_rate <= W'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_SPEED:  r_max_speed  <= w_cfg_val;
                REG_ACCEL_RATE: r_accel_rate <= w_cfg_val;
                default: ;
            endcase
        end
    end

    // Every stage moves together unless a finished result is held back.
    assign w_en       = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Stage 0: capture the transfer and form the signed distance.
    t_in_item r_s0_item;
    logic [W:0] r_s0_diff;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_item <= i_in_item;
            r_s0_diff <= {i_in_item.goal_position[W-1], i_in_item.goal_position}
                       - {i_in_item.start_position[W-1], i_in_item.start_position};
        end
    end

    // Stage 1: magnitude and direction, t squared and v squared.
    t_sb            n_s1_sb;
    t_sb            r_s1_sb;
    logic [2*W-1:0] r_s1_vv;
    logic [W:0]     w_neg;

    always_comb begin
        w_neg          = -r_s0_diff;
        n_s1_sb        = '0;
        n_s1_sb.start  = r_s0_item.start_position;
        n_s1_sb.goal   = r_s0_item.goal_position;
        n_s1_sb.t      = r_s0_item.elapsed_time;
        n_s1_sb.d      = r_s0_diff[W] ? w_neg[W-1:0] : r_s0_diff[W-1:0];
        n_s1_sb.up     = !r_s0_diff[W] && (r_s0_diff != '0);
        n_s1_sb.tt     = (2*W)'(r_s0_item.elapsed_time) * (2*W)'(r_s0_item.elapsed_time);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sb <= n_s1_sb;
            r_s1_vv <= (2*W)'(r_max_speed) * (2*W)'(r_max_speed);
        end
    end

    // Stage 2: d times a feeds the square root row.
    t_sb            r_s2_sb;
    logic [2*W-1:0] r_s2_vv;
    logic [2*W-1:0] r_s2_da;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sb <= r_s1_sb;
            r_s2_vv <= r_s1_vv;
            r_s2_da <= (2*W)'(r_s1_sb.d) * (2*W)'(r_accel_rate);
        end
    end

    // First row of cells: q = v*v / a and the triangular peak sqrt(d*a).
    logic [W-1:0]   w_qa_rem  [NA+1];
    logic [2*W-1:0] w_qa_num  [NA+1];
    logic [W+1:0]   w_sr_rem  [NS+1];
    logic [W-1:0]   w_sr_root [NS+1];
    logic [2*W-1:0] w_sr_x    [NS+1];
    t_sb            n_sa      [NA];
    t_sb            r_sa      [NA];

    assign w_qa_rem[0]  = '0;
    assign w_qa_num[0]  = r_s2_vv;
    assign w_sr_rem[0]  = '0;
    assign w_sr_root[0] = '0;
    assign w_sr_x[0]    = r_s2_da;

    for (genvar k = 0; k < NA; k++) begin : g_qa
        tmp_div_cell #(.DW(W), .NW(2*W)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_accel_rate),
            .i_rem (w_qa_rem[k]),
            .i_num (w_qa_num[k]),
            .o_rem (w_qa_rem[k+1]),
            .o_num (w_qa_num[k+1])
        );
    end

    for (genvar k = 0; k < NS; k++) begin : g_sr
        tmp_sqrt_cell #(.XW(2*W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_sr_rem[k]),
            .i_root (w_sr_root[k]),
            .i_x    (w_sr_x[k]),
            .o_rem  (w_sr_rem[k+1]),
            .o_root (w_sr_root[k+1]),
            .o_x    (w_sr_x[k+1])
        );
    end

    // The root leaves its cells halfway down the row and rides along from there.
    always_comb begin
        n_sa[0] = r_s2_sb;
        for (int k = 1; k < NA; k++) begin
            n_sa[k] = r_sa[k-1];
            if (k == NS) begin
                n_sa[k].root = w_sr_root[NS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa <= n_sa;
        end
    end

    // P1: trapezoid test, peak speed and distance left for cruising.
    t_sb          n_p1_sb;
    t_sb          r_p1_sb;
    logic [2*W-1:0] w_q;

    always_comb begin
        w_q          = w_qa_num[NA];
        n_p1_sb      = r_sa[NA-1];
        n_p1_sb.trap = ({{W{1'b0}}, r_sa[NA-1].d} > w_q);
        n_p1_sb.vp   = n_p1_sb.trap ? r_max_speed : r_sa[NA-1].root;
        n_p1_sb.dq   = n_p1_sb.trap ? (r_sa[NA-1].d - w_q[W-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_sb <= n_p1_sb;
        end
    end

    // P2: square of the peak speed for the ramp distance.
    t_sb            r_p2_sb;
    logic [2*W-1:0] r_p2_vpvp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_sb   <= r_p1_sb;
            r_p2_vpvp <= (2*W)'(r_p1_sb.vp) * (2*W)'(r_p1_sb.vp);
        end
    end

    // Second row of cells: ramp time, cruise time and ramp distance. The two
    // time quotients are zero-padded to the row length; vp*vp/(2a) is taken
    // as floor(vp*vp/2)/a.
    logic [W-1:0]  w_ta_rem [NB+1];
    logic [NB-1:0] w_ta_num [NB+1];
    logic [W-1:0]  w_tc_rem [NB+1];
    logic [NB-1:0] w_tc_num [NB+1];
    logic [W-1:0]  w_rp_rem [NB+1];
    logic [NB-1:0] w_rp_num [NB+1];
    t_sb           r_sb_b   [NB];

    assign w_ta_rem[0] = '0;
    assign w_ta_num[0] = {{(NB-TW){1'b0}}, r_p2_sb.vp, {FRAC_BITS{1'b0}}};
    assign w_tc_rem[0] = '0;
    assign w_tc_num[0] = {{(NB-TW){1'b0}}, r_p2_sb.dq, {FRAC_BITS{1'b0}}};
    assign w_rp_rem[0] = '0;
    assign w_rp_num[0] = r_p2_vpvp[2*W-1:1];

    for (genvar k = 0; k < NB; k++) begin : g_b
        tmp_div_cell #(.DW(W), .NW(NB)) u_ta (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_accel_rate),
            .i_rem (w_ta_rem[k]),
            .i_num (w_ta_num[k]),
            .o_rem (w_ta_rem[k+1]),
            .o_num (w_ta_num[k+1])
        );
        tmp_div_cell #(.DW(W), .NW(NB)) u_tc (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_max_speed),
            .i_rem (w_tc_rem[k]),
            .i_num (w_tc_num[k]),
            .o_rem (w_tc_rem[k+1]),
            .o_num (w_tc_num[k+1])
        );
        tmp_div_cell #(.DW(W), .NW(NB)) u_rp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_accel_rate),
            .i_rem (w_rp_rem[k]),
            .i_num (w_rp_num[k]),
            .o_rem (w_rp_rem[k+1]),
            .o_num (w_rp_num[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_b[0] <= r_p2_sb;
            for (int k = 1; k < NB; k++) begin
                r_sb_b[k] <= r_sb_b[k-1];
            end
        end
    end

    // C1: end of cruise, ta + tc.
    t_sb           r_c1_sb;
    logic [TW-1:0] r_c1_ta;
    logic [TW-1:0] r_c1_tc;
    logic [NB-1:0] r_c1_ramp;
    logic [EW-1:0] r_c1_e2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_sb   <= r_sb_b[NB-1];
            r_c1_ta   <= w_ta_num[NB][TW-1:0];
            r_c1_tc   <= w_tc_num[NB][TW-1:0];
            r_c1_ramp <= w_rp_num[NB];
            r_c1_e2   <= EW'(w_ta_num[NB][TW-1:0]) + EW'(w_tc_num[NB][TW-1:0]);
        end
    end

    // C2: end of deceleration and the first two time compares.
    t_sb           r_c2_sb;
    logic [TW-1:0] r_c2_ta;
    logic [TW-1:0] r_c2_tc;
    logic [NB-1:0] r_c2_ramp;
    logic [EW-1:0] r_c2_e2;
    logic [EW-1:0] r_c2_e3;
    logic          r_c2_le1;
    logic          r_c2_le2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2_sb   <= r_c1_sb;
            r_c2_ta   <= r_c1_ta;
            r_c2_tc   <= r_c1_tc;
            r_c2_ramp <= r_c1_ramp;
            r_c2_e2   <= r_c1_e2;
            r_c2_e3   <= r_c1_e2 + EW'(r_c1_ta);
            r_c2_le1  <= (TW'(r_c1_sb.t) <= r_c1_ta);
            r_c2_le2  <= (EW'(r_c1_sb.t) <= r_c1_e2);
        end
    end

    // C3: phase decision and the time offsets into cruise and deceleration.
    // Those offsets are below 2^32 whenever their phase applies.
    t_sb           r_c3_sb;
    t_phase        n_c3_phase;
    t_phase        r_c3_phase;
    logic [W-1:0]  r_c3_dt1;
    logic [W-1:0]  r_c3_u;
    logic [W-1:0]  r_c3_tc;
    logic [NB-1:0] r_c3_ramp;

    always_comb begin
        priority if (r_c2_le1) begin
            n_c3_phase = PH_ACCEL;
        end else if (r_c2_le2) begin
            n_c3_phase = PH_CRUISE;
        end else if (EW'(r_c2_sb.t) <= r_c2_e3) begin
            n_c3_phase = PH_DECEL;
        end else begin
            n_c3_phase = PH_ARRIVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3_sb    <= r_c2_sb;
            r_c3_phase <= n_c3_phase;
            r_c3_dt1   <= r_c2_sb.t - r_c2_ta[W-1:0];
            r_c3_u     <= r_c2_sb.t - r_c2_e2[W-1:0];
            r_c3_tc    <= r_c2_tc[W-1:0];
            r_c3_ramp  <= r_c2_ramp;
        end
    end

    // C4: u squared and the speed-times-time products.
    t_sb            r_c4_sb;
    t_phase         r_c4_phase;
    logic [NB-1:0]  r_c4_ramp;
    logic [2*W-1:0] r_c4_uu;
    logic [2*W-1:0] r_c4_cr;
    logic [2*W-1:0] r_c4_gain;
    logic [2*W-1:0] r_c4_vptc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c4_sb    <= r_c3_sb;
            r_c4_phase <= r_c3_phase;
            r_c4_ramp  <= r_c3_ramp;
            r_c4_uu    <= (2*W)'(r_c3_u) * (2*W)'(r_c3_u);
            r_c4_cr    <= (2*W)'(r_max_speed) * (2*W)'(r_c3_dt1);
            r_c4_gain  <= (2*W)'(r_c3_sb.vp) * (2*W)'(r_c3_u);
            r_c4_vptc  <= (2*W)'(r_c3_sb.vp) * (2*W)'(r_c3_tc);
        end
    end

    // C5: a times a squared time, as two partial products. One product serves
    // both the acceleration distance and the deceleration loss.
    t_sb            r_c5_sb;
    t_phase         r_c5_phase;
    logic [NB-1:0]  r_c5_ramp;
    logic [2*W-1:0] r_c5_cr;
    logic [2*W-1:0] r_c5_gain;
    logic [2*W-1:0] r_c5_vptc;
    logic [2*W-1:0] r_c5_plo;
    logic [2*W-1:0] r_c5_phi;
    logic [2*W-1:0] w_sq;

    assign w_sq = (r_c4_phase == PH_ACCEL) ? r_c4_sb.tt : r_c4_uu;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c5_sb    <= r_c4_sb;
            r_c5_phase <= r_c4_phase;
            r_c5_ramp  <= r_c4_ramp;
            r_c5_cr    <= r_c4_cr;
            r_c5_gain  <= r_c4_gain;
            r_c5_vptc  <= r_c4_vptc;
            r_c5_plo   <= (2*W)'(r_accel_rate) * (2*W)'(w_sq[W-1:0]);
            r_c5_phi   <= (2*W)'(r_accel_rate) * (2*W)'(w_sq[2*W-1:W]);
        end
    end

    // C6: quadratic term, ramp plus the linear term, and the deceleration gain.
    t_sb            r_c6_sb;
    t_phase         r_c6_phase;
    logic [PW-1:0]  r_c6_quad;
    logic [PW-1:0]  r_c6_base;
    logic [2*W-1:0] r_c6_g;
    logic [PW-1:0]  w_prod;
    logic [2*W-1:0] w_lin;

    always_comb begin
        w_prod = {r_c5_phi, {W{1'b0}}} + {{W{1'b0}}, r_c5_plo};
        w_lin  = (r_c5_phase == PH_CRUISE) ? r_c5_cr : r_c5_vptc;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c6_sb    <= r_c5_sb;
            r_c6_phase <= r_c5_phase;
            r_c6_quad  <= w_prod >> (2 * FRAC_BITS + 1);
            r_c6_base  <= PW'(r_c5_ramp) + PW'(w_lin >> FRAC_BITS);
            r_c6_g     <= r_c5_gain >> FRAC_BITS;
        end
    end

    // C7: net deceleration distance, never below zero.
    t_sb           r_c7_sb;
    t_phase        r_c7_phase;
    logic [PW-1:0] r_c7_quad;
    logic [PW-1:0] r_c7_base;
    logic [PW-1:0] r_c7_net;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c7_sb    <= r_c6_sb;
            r_c7_phase <= r_c6_phase;
            r_c7_quad  <= r_c6_quad;
            r_c7_base  <= r_c6_base;
            r_c7_net   <= (PW'(r_c6_g) > r_c6_quad) ? (PW'(r_c6_g) - r_c6_quad) : '0;
        end
    end

    // C8: traveled distance for the phase.
    t_sb           r_c8_sb;
    t_phase        r_c8_phase;
    logic [PW-1:0] r_c8_s;
    logic [PW-1:0] n_c8_s;

    always_comb begin
        unique case (r_c7_phase)
            PH_ACCEL:  n_c8_s = r_c7_quad;
            PH_CRUISE: n_c8_s = r_c7_base;
            PH_DECEL:  n_c8_s = r_c7_base + r_c7_net;
            default:   n_c8_s = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c8_sb    <= r_c7_sb;
            r_c8_phase <= r_c7_phase;
            r_c8_s     <= n_c8_s;
        end
    end

    // Output register: clamp to the distance and step from the start. The
    // clamped position lies between start and goal, so it never overflows.
    t_out_item    r_out;
    logic [W-1:0] w_sc;
    logic [W-1:0] w_pos;

    always_comb begin
        w_sc = (r_c8_s > PW'(r_c8_sb.d)) ? r_c8_sb.d : r_c8_s[W-1:0];
        if (r_c8_phase == PH_ARRIVED) begin
            w_pos = r_c8_sb.goal;
        end else if (r_c8_sb.up) begin
            w_pos = r_c8_sb.start + w_sc;
        end else begin
            w_pos = r_c8_sb.start - w_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.planned_position <= $signed(w_pos);
            r_out.move_phase       <= r_c8_phase;
            r_out.triangular       <= !r_c8_sb.trap;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_out_item  = r_out;

    `ASSERT_ALWAYS(a_cfg_nonzero, (r_max_speed != '0) && (r_accel_rate != '0),
        "speed or acceleration register holds zero")
    `ASSERT_NEXT(a_hold_on_stall, o_out_valid && i_out_stall, $stable(r_vld),
        "pipeline moved while the output was stalled")
    `ASSERT_IMPL(a_cruise_trap, o_out_valid && (o_out_item.move_phase == PH_CRUISE),
        !o_out_item.triangular, "cruise phase reported for a triangular profile")
    `ASSERT_IMPL(a_trap_gap, r_vld[P1_IDX] && r_p1_sb.trap, r_p1_sb.dq != '0,
        "trapezoid found with no distance left for cruising")

endmodule

`default_nettype wire

[rtl/tmp_div_cell.sv]
// One registered restoring division step: one quotient bit per cell.
`default_nettype none

module tmp_div_cell #(
    parameter int DW = 32,
    parameter int NW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [NW-1:0] i_num,
    output logic      [DW-1:0] o_rem,
    output logic      [NW-1:0] o_num
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
        w_trial = {i_rem, i_num[NW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_num   = {i_num[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;

endmodule

`default_nettype wire

[rtl/tmp_sqrt_cell.sv]
// One registered digit-by-digit square root step: one root bit per cell.
`default_nettype none

module tmp_sqrt_cell #(
    parameter int XW = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW/2+1:0]   i_rem,
    input  wire logic [XW/2-1:0]   i_root,
    input  wire logic [XW-1:0]     i_x,
    output logic      [XW/2+1:0]   o_rem,
    output logic      [XW/2-1:0]   o_root,
    output logic      [XW-1:0]     o_x
);

    localparam int RW = XW / 2;

    logic [RW+3:0] w_tr;
    logic [RW+3:0] w_trial;
    logic [RW+3:0] w_diff;
    logic          w_ge;
    logic [RW+1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [XW-1:0] r_x;

    // Bring down the next two radicand bits and try the digit one.
    always_comb begin
        w_tr    = {i_rem, i_x[XW-1:XW-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_tr - w_trial;
        w_ge    = (w_tr >= w_trial);
        n_rem   = w_ge ? w_diff[RW+1:0] : w_tr[RW+1:0];
        n_root  = {i_root[RW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_x    <= {i_x[XW-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_x    = r_x;

endmodule

`default_nettype wire
